>>> rtl/core/svpwm_pkg.sv
// ============================================================================
// svpwm_pkg
// Shared types and constants for the servo PWM channel bank.
// ============================================================================
`default_nettype none

package svpwm_pkg;

  localparam int NUM_CHANNELS = 5;
  localparam int PIN_W        = 5;
  localparam int PIN_COUNT    = (NUM_CHANNELS < PIN_W) ? NUM_CHANNELS : PIN_W;
  localparam int PULSE_W      = 16;
  localparam int KIND_W       = 3;
  localparam int CH_W         = 3;
  localparam int CFG_IDX_W    = 3;

  localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET_RAW  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET_CRSF = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SET_NORM = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ENABLE   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE_DIV  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_RELOAD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_CENTER  = 3'd4;

  localparam logic [PULSE_W-1:0] RESET_PRESCALE_DIV  = 16'd107;
  localparam logic [PULSE_W-1:0] RESET_PERIOD_RELOAD = 16'd19999;
  localparam logic [PULSE_W-1:0] RESET_PULSE_MIN     = 16'd1000;
  localparam logic [PULSE_W-1:0] RESET_PULSE_MAX     = 16'd2000;
  localparam logic [PULSE_W-1:0] RESET_PULSE_CENTER  = 16'd1500;

  localparam logic [PULSE_W-1:0] CRSF_LOW       = 16'd172;
  localparam logic [PULSE_W-1:0] CRSF_HIGH      = 16'd1811;
  localparam logic [PULSE_W-1:0] CRSF_OUT_BASE  = 16'd1000;
  localparam int                 CRSF_D_W       = 11;
  localparam int                 CRSF_RECIP_W   = 20;
  localparam int                 CRSF_PROD_W    = CRSF_D_W + CRSF_RECIP_W;
  // Rounded-up value of 1000 * 2^20 / 1639, exact for every clamped CRSF input.
  localparam logic [CRSF_RECIP_W-1:0] CRSF_RECIP = 20'd639766;

  localparam logic signed [PULSE_W-1:0] NORM_POS = 16'sh4000;
  localparam logic signed [PULSE_W-1:0] NORM_NEG = 16'shC000;
  localparam int                        NORM_SHIFT  = 14;
  localparam int                        NORM_PROD_W = 24;
  localparam int                        NORM_T_W    = NORM_PROD_W - NORM_SHIFT;
  localparam logic [8:0]                NORM_SCALE  = 9'd500;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_SET_PULSE,
    OP_SET_NORM,
    OP_ENABLE,
    OP_READ,
    OP_READ_CENTER
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [CH_W-1:0]    channel;
    logic [PULSE_W-1:0] value;
    logic               enable;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/core/svpwm_in_if.sv
// ============================================================================
// svpwm_in_if
// Request channel carrying one tick, write, enable or read item.
// ============================================================================
`default_nettype none

interface svpwm_in_if import svpwm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [CH_W-1:0]           channel;
  logic [PULSE_W-1:0]        pulse_value;
  logic signed [PULSE_W-1:0] norm_value;
  logic                      enable_flag;

  modport source (output valid, kind, channel, pulse_value, norm_value, enable_flag,
                  input ready);
  modport sink (input valid, kind, channel, pulse_value, norm_value, enable_flag,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/svpwm_out_if.sv
// ============================================================================
// svpwm_out_if
// Result channel carrying pin levels, period start and readback.
// ============================================================================
`default_nettype none

interface svpwm_out_if import svpwm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIN_W-1:0]   pin_levels;
  logic               period_start;
  logic [PULSE_W-1:0] pulse_readback;

  modport source (output valid, pin_levels, period_start, pulse_readback, input ready);
  modport sink (input valid, pin_levels, period_start, pulse_readback, output ready);
endinterface

`default_nettype wire

>>> rtl/core/svpwm_cfg_if.sv
// ============================================================================
// svpwm_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
`default_nettype none

interface svpwm_cfg_if import svpwm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PULSE_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/svpwm_front.sv
// ============================================================================
// svpwm_front
// Accepts requests, classifies them and scales CRSF and normalized values.
// ============================================================================
`default_nettype none

module svpwm_front import svpwm_pkg::*; (
  svpwm_in_if.sink   in_req,
  input  logic       q_full,
  output logic       push,
  output item_t      push_item
);

  logic                      ch_ok;
  logic [PULSE_W-1:0]        crsf_c;
  logic [CRSF_D_W-1:0]       crsf_d;
  logic [CRSF_PROD_W-1:0]    crsf_prod;
  logic signed [PULSE_W-1:0] norm_c;
  logic [PULSE_W-1:0]        norm_s;
  logic [NORM_PROD_W-1:0]    norm_prod;

  assign in_req.ready = !q_full;
  assign push         = in_req.valid && !q_full;

  always_comb begin
    ch_ok = ({1'b0, in_req.channel} < (CH_W + 1)'(NUM_CHANNELS));

    crsf_c = in_req.pulse_value;
    if (crsf_c < CRSF_LOW) begin
      crsf_c = CRSF_LOW;
    end
    if (crsf_c > CRSF_HIGH) begin
      crsf_c = CRSF_HIGH;
    end
    crsf_d    = CRSF_D_W'(crsf_c - CRSF_LOW);
    crsf_prod = {{CRSF_RECIP_W{1'b0}}, crsf_d} * {{CRSF_D_W{1'b0}}, CRSF_RECIP};

    norm_c = in_req.norm_value;
    if (norm_c < NORM_NEG) begin
      norm_c = NORM_NEG;
    end
    if (norm_c > NORM_POS) begin
      norm_c = NORM_POS;
    end
    norm_s    = PULSE_W'(norm_c + NORM_POS);
    norm_prod = {{(NORM_PROD_W - PULSE_W){1'b0}}, norm_s} * NORM_PROD_W'(NORM_SCALE);

    push_item.op      = OP_NOP;
    push_item.channel = in_req.channel;
    push_item.value   = in_req.pulse_value;
    push_item.enable  = in_req.enable_flag;

    unique case (in_req.kind)
      KIND_TICK: begin
        push_item.op = OP_TICK;
      end
      KIND_SET_RAW: begin
        push_item.op = ch_ok ? OP_SET_PULSE : OP_NOP;
      end
      KIND_SET_CRSF: begin
        push_item.op    = ch_ok ? OP_SET_PULSE : OP_NOP;
        push_item.value = CRSF_OUT_BASE +
                          PULSE_W'(crsf_prod[CRSF_PROD_W-1:CRSF_RECIP_W]);
      end
      KIND_SET_NORM: begin
        push_item.op    = ch_ok ? OP_SET_NORM : OP_NOP;
        push_item.value = PULSE_W'(norm_prod[NORM_PROD_W-1:NORM_SHIFT]);
      end
      KIND_ENABLE: begin
        push_item.op = ch_ok ? OP_ENABLE : OP_NOP;
      end
      KIND_READ: begin
        push_item.op = ch_ok ? OP_READ : OP_READ_CENTER;
      end
      default: begin
        push_item.op = OP_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/svpwm_queue.sv
// ============================================================================
// svpwm_queue
// Short FIFO of classified requests between the front and back parts.
// ============================================================================
`default_nettype none

module svpwm_queue import svpwm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  q_valid,
  output item_t q_item,
  input  logic  pop
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/svpwm_back.sv
// ============================================================================
// svpwm_back
// Holds the timer, pulse and enable state, executes requests in order and
// registers one result per request.
// ============================================================================
`default_nettype none

module svpwm_back import svpwm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  svpwm_cfg_if.sink   cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        pop,
  svpwm_out_if.source out_res
);

  logic [PULSE_W-1:0] prescale_div;
  logic [PULSE_W-1:0] period_reload;
  logic [PULSE_W-1:0] pulse_min;
  logic [PULSE_W-1:0] pulse_max;
  logic [PULSE_W-1:0] pulse_center;

  logic [PULSE_W-1:0] prescale_count;
  logic [PULSE_W-1:0] prescale_count_next;
  logic [PULSE_W-1:0] period_count;
  logic [PULSE_W-1:0] period_count_next;
  logic [PULSE_W-1:0] requested_pulse      [NUM_CHANNELS];
  logic [PULSE_W-1:0] requested_pulse_next [NUM_CHANNELS];
  logic [PULSE_W-1:0] active_compare       [NUM_CHANNELS];
  logic [PULSE_W-1:0] active_compare_next  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] channel_enabled;
  logic [NUM_CHANNELS-1:0] channel_enabled_next;

  logic                 out_valid;
  logic [PIN_W-1:0]     pin_levels;
  logic [PIN_W-1:0]     pin_levels_next;
  logic                 period_start;
  logic                 period_start_next;
  logic [PULSE_W-1:0]   pulse_readback;
  logic [PULSE_W-1:0]   pulse_readback_next;

  logic                 exec;
  logic [PULSE_W+1:0]   norm_sum;
  logic [PULSE_W-1:0]   norm_sat;
  logic [PULSE_W-1:0]   set_val;
  logic [PULSE_W-1:0]   clamped;

  assign cfg.ready            = 1'b1;
  assign exec                 = q_valid && (!out_valid || out_res.ready);
  assign pop                  = exec;
  assign out_res.valid        = out_valid;
  assign out_res.pin_levels   = pin_levels;
  assign out_res.period_start = period_start;
  assign out_res.pulse_readback = pulse_readback;

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_div  <= RESET_PRESCALE_DIV;
      period_reload <= RESET_PERIOD_RELOAD;
      pulse_min     <= RESET_PULSE_MIN;
      pulse_max     <= RESET_PULSE_MAX;
      pulse_center  <= RESET_PULSE_CENTER;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_PRESCALE_DIV:  prescale_div  <= cfg.data;
        CFG_PERIOD_RELOAD: period_reload <= cfg.data;
        CFG_PULSE_MIN:     pulse_min     <= cfg.data;
        CFG_PULSE_MAX:     pulse_max     <= cfg.data;
        CFG_PULSE_CENTER:  pulse_center  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prescale_count_next  = prescale_count;
    period_count_next    = period_count;
    requested_pulse_next = requested_pulse;
    active_compare_next  = active_compare;
    channel_enabled_next = channel_enabled;
    period_start_next    = 1'b0;
    pulse_readback_next  = '0;

    norm_sum = {2'b00, pulse_center} + {2'b00, q_item.value} - (PULSE_W + 2)'(NORM_SCALE);
    if (norm_sum[PULSE_W+1]) begin
      norm_sat = '0;
    end else if (norm_sum[PULSE_W]) begin
      norm_sat = '1;
    end else begin
      norm_sat = norm_sum[PULSE_W-1:0];
    end

    set_val = (q_item.op == OP_SET_NORM) ? norm_sat : q_item.value;
    clamped = set_val;
    if (clamped < pulse_min) begin
      clamped = pulse_min;
    end
    if (clamped > pulse_max) begin
      clamped = pulse_max;
    end

    unique case (q_item.op) inside
      OP_TICK: begin
        if (prescale_count >= prescale_div) begin
          prescale_count_next = '0;
          if (period_count >= period_reload) begin
            period_count_next   = '0;
            period_start_next   = 1'b1;
            active_compare_next = requested_pulse;
          end else begin
            period_count_next = period_count + 1'b1;
          end
        end else begin
          prescale_count_next = prescale_count + 1'b1;
        end
      end
      OP_SET_PULSE, OP_SET_NORM: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (q_item.channel == CH_W'(i)) begin
            requested_pulse_next[i] = clamped;
          end
        end
      end
      OP_ENABLE: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (q_item.channel == CH_W'(i)) begin
            channel_enabled_next[i] = q_item.enable;
          end
        end
      end
      OP_READ: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (q_item.channel == CH_W'(i)) begin
            pulse_readback_next = requested_pulse[i];
          end
        end
      end
      OP_READ_CENTER: begin
        pulse_readback_next = pulse_center;
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase

    pin_levels_next = '0;
    for (int i = 0; i < PIN_COUNT; i++) begin
      pin_levels_next[i] = channel_enabled_next[i] &&
                           (period_count_next < active_compare_next[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count  <= '0;
      period_count    <= '0;
      channel_enabled <= '1;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        requested_pulse[i] <= RESET_PULSE_CENTER;
        active_compare[i]  <= RESET_PULSE_CENTER;
      end
    end else if (exec) begin
      prescale_count  <= prescale_count_next;
      period_count    <= period_count_next;
      channel_enabled <= channel_enabled_next;
      requested_pulse <= requested_pulse_next;
      active_compare  <= active_compare_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (out_res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      pin_levels     <= pin_levels_next;
      period_start   <= period_start_next;
      pulse_readback <= pulse_readback_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/servo_pwm_channel_bank_unit.sv
// ============================================================================
// servo_pwm_channel_bank_unit
// Bank of servo PWM channels driven by timer tick requests.
//
// Requests arrive on in_req: a tick advances the prescaler and the period
// counter by one timer clock; other requests write a raw, CRSF or normalized
// pulse into a channel's shadow register, enable or stop a channel, or read
// back its stored pulse. Shadow pulses move into the active compares when the
// counter wraps. Every request yields exactly one result on out_res with the
// pin levels after the request, the period start flag and the readback.
// The front stage classifies and scales a request in the cycle it is taken,
// a two-entry queue holds it, and the back stage executes it and registers
// the result. One request per cycle is sustained while the receiver takes
// every result; the limit is the single state update in the back stage.
// When the receiver stalls, the output register holds its result and
// the queue fills, after which in_req.ready falls. Configuration writes on
// cfg are always taken. Synchronous reset loads the default registers, sets
// every pulse to the center value, enables all channels and empties the queue.
// ============================================================================
`default_nettype none

module servo_pwm_channel_bank_unit import svpwm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  svpwm_in_if.sink    in_req,
  svpwm_out_if.source out_res,
  svpwm_cfg_if.sink   cfg
);

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_valid;
  item_t q_item;
  logic  pop;

  svpwm_front u_front (
    .in_req    (in_req),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  svpwm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  svpwm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking testbench for the servo PWM channel bank.
//
// A queue of requests feeds a clocked driver. An internal model of the bank
// tracks the prescaler, the period counter, the shadow and active compares
// and the channel enables. It also tracks the register settings. At each
// accepted request the model works out the one result that the request
// yields and stores it in order. A clocked monitor takes each result and
// compares it with the oldest stored one.
// A short directed part runs at the reset settings. After it come random
// phases. Each phase first writes a new register setting while the bank is
// idle. Both sides pause at random, with calm stretches in between.
// ============================================================================
module tb_top;
  import svpwm_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = KIND_READ + 3'd1;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = '1;
  localparam int CH_TOP = (1 << CH_W) - 1;
  localparam int GAP_MAX = 17;
  localparam int SHOW_MAX = 10;
  localparam int CRSF_OUT_SPAN = 1000;
  localparam int CRSF_IN_SPAN = 1639;
  localparam int NORM_FULL = 16384;
  localparam int NORM_GAIN = 500;
  localparam int PULSE_TOP = (1 << PULSE_W) - 1;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [CH_W-1:0]           channel;
    logic [PULSE_W-1:0]        pulse_value;
    logic signed [PULSE_W-1:0] norm_value;
    logic                      enable_flag;
  } pwm_req_t;

  typedef struct packed {
    logic [PIN_W-1:0]   pins;
    logic               wrap;
    logic [PULSE_W-1:0] readback;
  } pwm_res_t;

  logic clk;
  logic rst;

  svpwm_in_if  in_req();
  svpwm_out_if out_res();
  svpwm_cfg_if cfg();

  servo_pwm_channel_bank_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg     (cfg)
  );

  logic [PULSE_W-1:0] div_r, reload_r, min_r, max_r, center_r;
  logic [PULSE_W-1:0] presc_cnt, step_cnt;
  logic [PULSE_W-1:0] shadow_pulse [NUM_CHANNELS];
  logic [PULSE_W-1:0] live_cmp [NUM_CHANNELS];
  logic               ch_run [NUM_CHANNELS];

  pwm_req_t req_backlog[$];
  pwm_res_t pwm_expect_q[$];
  pwm_req_t req_live;
  int       send_wait, recv_wait, mismatch_cnt;
  logic     send_calm, recv_calm;

  function automatic logic [PULSE_W-1:0] limit_pulse(int unsigned p);
    if (p < min_r) p = 32'(min_r);
    if (p > max_r) p = 32'(max_r);
    return p[PULSE_W-1:0];
  endfunction

  function automatic void store_pulse(logic [CH_W-1:0] ch, int unsigned p);
    if (ch < NUM_CHANNELS) shadow_pulse[ch] = limit_pulse(p);
  endfunction

  function automatic pwm_res_t servo_bank_step(pwm_req_t rq);
    pwm_res_t    rs;
    int unsigned crsf;
    int          nrm, sum;
    rs = '0;
    case (rq.kind)
      KIND_TICK: begin
        if (presc_cnt >= div_r) begin
          presc_cnt = '0;
          if (step_cnt >= reload_r) begin
            step_cnt = '0;
            rs.wrap = 1'b1;
            for (int i = 0; i < NUM_CHANNELS; i++) live_cmp[i] = shadow_pulse[i];
          end else begin
            step_cnt = step_cnt + 1'b1;
          end
        end else begin
          presc_cnt = presc_cnt + 1'b1;
        end
      end
      KIND_SET_RAW: store_pulse(rq.channel, 32'(rq.pulse_value));
      KIND_SET_CRSF: begin
        crsf = 32'(rq.pulse_value);
        if (crsf < CRSF_LOW) crsf = 32'(CRSF_LOW);
        if (crsf > CRSF_HIGH) crsf = 32'(CRSF_HIGH);
        store_pulse(rq.channel,
                    32'(CRSF_OUT_BASE) +
                    (crsf - 32'(CRSF_LOW)) * CRSF_OUT_SPAN / CRSF_IN_SPAN);
      end
      KIND_SET_NORM: begin
        nrm = $signed(rq.norm_value);
        if (nrm < -NORM_FULL) nrm = -NORM_FULL;
        if (nrm > NORM_FULL) nrm = NORM_FULL;
        // The offset keeps the dividend non-negative, so the division floors.
        sum = int'(center_r) + ((nrm + NORM_FULL) * NORM_GAIN) / NORM_FULL - NORM_GAIN;
        if (sum < 0) sum = 0;
        if (sum > PULSE_TOP) sum = PULSE_TOP;
        store_pulse(rq.channel, sum);
      end
      KIND_ENABLE: begin
        if (rq.channel < NUM_CHANNELS) ch_run[rq.channel] = rq.enable_flag;
      end
      KIND_READ: begin
        rs.readback = (rq.channel < NUM_CHANNELS) ? shadow_pulse[rq.channel] : center_r;
      end
      default: ;
    endcase
    for (int i = 0; i < PIN_COUNT; i++) rs.pins[i] = ch_run[i] && (step_cnt < live_cmp[i]);
    return rs;
  endfunction

  function automatic pwm_req_t mk_req(logic [KIND_W-1:0] kind, logic [CH_W-1:0] ch,
                                      logic [PULSE_W-1:0] pv, logic [PULSE_W-1:0] nv,
                                      logic en);
    pwm_req_t rq;
    rq.kind        = kind;
    rq.channel     = ch;
    rq.pulse_value = pv;
    rq.norm_value  = nv;
    rq.enable_flag = en;
    return rq;
  endfunction

  function automatic pwm_req_t draw_request();
    pwm_req_t    rq;
    int unsigned roll;
    rq.kind        = KIND_TICK;
    rq.channel     = CH_W'(($urandom_range(0, 9) < 8) ? $urandom_range(0, NUM_CHANNELS - 1)
                                                       : $urandom_range(NUM_CHANNELS, CH_TOP));
    rq.pulse_value = PULSE_W'($urandom);
    rq.norm_value  = PULSE_W'($urandom);
    rq.enable_flag = ($urandom_range(0, 3) != 0);
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      rq.kind = KIND_TICK;
    end else if (roll < 60) begin
      rq.kind = KIND_SET_RAW;
      if ($urandom_range(0, 2) != 0)
        rq.pulse_value = PULSE_W'($urandom_range(0, reload_r + 4));
    end else if (roll < 70) begin
      rq.kind = KIND_SET_CRSF;
      if ($urandom_range(0, 2) != 0) rq.pulse_value = PULSE_W'($urandom_range(150, 1850));
    end else if (roll < 80) begin
      rq.kind = KIND_SET_NORM;
      if ($urandom_range(0, 2) != 0)
        rq.norm_value = PULSE_W'(int'($urandom_range(0, 2 * NORM_FULL)) - NORM_FULL);
    end else if (roll < 88) begin
      rq.kind = KIND_ENABLE;
    end else if (roll < 98) begin
      rq.kind = KIND_READ;
    end else begin
      rq.kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    end
    return rq;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PULSE_W-1:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      CFG_PRESCALE_DIV:  div_r    = val;
      CFG_PERIOD_RELOAD: reload_r = val;
      CFG_PULSE_MIN:     min_r    = val;
      CFG_PULSE_MAX:     max_r    = val;
      CFG_PULSE_CENTER:  center_r = val;
      default: ;
    endcase
    cfg.valid <= 1'b0;
  endtask

  task automatic settle();
    while (req_backlog.size() != 0 || in_req.valid || pwm_expect_q.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(int n);
    repeat (n) req_backlog.push_back(draw_request());
    settle();
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    logic launch, hold;
    if (rst) begin
      in_req.valid <= 1'b0;
    end else begin
      launch = 1'b0;
      hold = in_req.valid && !in_req.ready;
      if (in_req.valid && in_req.ready) begin
        pwm_expect_q.push_back(servo_bank_step(req_live));
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        send_wait = send_calm ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (!hold) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (req_backlog.size() != 0) begin
          req_live = req_backlog.pop_front();
          launch = 1'b1;
        end
        in_req.valid <= launch;
        if (launch) begin
          in_req.kind        <= req_live.kind;
          in_req.channel     <= req_live.channel;
          in_req.pulse_value <= req_live.pulse_value;
          in_req.norm_value  <= req_live.norm_value;
          in_req.enable_flag <= req_live.enable_flag;
        end
      end
    end
  end

  always @(posedge clk) begin
    pwm_res_t want;
    if (rst) begin
      out_res.ready <= 1'b0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        if (pwm_expect_q.size() == 0) begin
          if (mismatch_cnt < SHOW_MAX)
            $display("%0t: result with nothing pending: pins=%b start=%b readback=%0d",
                     $time, out_res.pin_levels, out_res.period_start,
                     out_res.pulse_readback);
          mismatch_cnt++;
        end else begin
          want = pwm_expect_q.pop_front();
          if (out_res.pin_levels !== want.pins || out_res.period_start !== want.wrap ||
              out_res.pulse_readback !== want.readback) begin
            if (mismatch_cnt < SHOW_MAX)
              $display("%0t: expected pins=%b start=%b readback=%0d, got %b %b %0d",
                       $time, want.pins, want.wrap, want.readback, out_res.pin_levels,
                       out_res.period_start, out_res.pulse_readback);
            mismatch_cnt++;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, GAP_MAX);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_res.ready <= (recv_wait == 0);
    end
  end

  initial begin
    rst = 1'b1;
    in_req.valid = 1'b0;
    in_req.kind = KIND_TICK;
    in_req.channel = '0;
    in_req.pulse_value = '0;
    in_req.norm_value = '0;
    in_req.enable_flag = 1'b0;
    out_res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_PRESCALE_DIV;
    cfg.data = '0;
    send_wait = 0;
    recv_wait = 0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    mismatch_cnt = 0;
    div_r = RESET_PRESCALE_DIV;
    reload_r = RESET_PERIOD_RELOAD;
    min_r = RESET_PULSE_MIN;
    max_r = RESET_PULSE_MAX;
    center_r = RESET_PULSE_CENTER;
    presc_cnt = '0;
    step_cnt = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      shadow_pulse[i] = RESET_PULSE_CENTER;
      live_cmp[i] = RESET_PULSE_CENTER;
      ch_run[i] = 1'b1;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: clamps, scaling edges, ignored channels and spare kinds.
    req_backlog.push_back(mk_req(KIND_READ, 0, 16'hFFFF, 16'h8000, 1'b0));
    req_backlog.push_back(mk_req(KIND_READ, CH_TOP, 0, 0, 1'b1));
    req_backlog.push_back(mk_req(KIND_SET_RAW, 0, 0, 16'h7FFF, 1'b1));
    req_backlog.push_back(mk_req(KIND_SET_RAW, 1, 16'hFFFF, 0, 1'b0));
    req_backlog.push_back(mk_req(KIND_SET_CRSF, 2, 0, 0, 1'b0));
    req_backlog.push_back(mk_req(KIND_SET_CRSF, 3, 16'hFFFF, 0, 1'b0));
    req_backlog.push_back(mk_req(KIND_SET_CRSF, 4, 992, 0, 1'b0));
    req_backlog.push_back(mk_req(KIND_SET_NORM, 0, 0, 16'h8000, 1'b0));
    req_backlog.push_back(mk_req(KIND_SET_NORM, 1, 0, 16'h7FFF, 1'b0));
    req_backlog.push_back(mk_req(KIND_SET_NORM, 2, 0, 16'hFFFF, 1'b0));
    req_backlog.push_back(mk_req(KIND_SET_NORM, 3, 0, 16'hC000, 1'b0));
    req_backlog.push_back(mk_req(KIND_SET_NORM, 4, 0, 16'h4000, 1'b0));
    req_backlog.push_back(mk_req(KIND_SET_RAW, NUM_CHANNELS, 1234, 0, 1'b0));
    req_backlog.push_back(mk_req(KIND_ENABLE, CH_TOP - 1, 0, 0, 1'b0));
    req_backlog.push_back(mk_req(KIND_ENABLE, NUM_CHANNELS - 1, 0, 0, 1'b0));
    req_backlog.push_back(mk_req(KIND_TICK, 0, 0, 0, 1'b0));
    req_backlog.push_back(mk_req(KIND_SPARE_LO, 1, 16'hFFFF, 16'hFFFF, 1'b1));
    req_backlog.push_back(mk_req(KIND_SPARE_HI, 2, 16'h5555, 16'hAAAA, 1'b1));
    req_backlog.push_back(mk_req(KIND_READ, 2, 0, 0, 1'b0));
    req_backlog.push_back(mk_req(KIND_ENABLE, NUM_CHANNELS - 1, 0, 0, 1'b1));
    req_backlog.push_back(mk_req(KIND_READ, NUM_CHANNELS - 1, 0, 0, 1'b0));
    req_backlog.push_back(mk_req(KIND_TICK, CH_TOP, 16'hFFFF, 16'hFFFF, 1'b1));
    settle();

    write_reg(CFG_PRESCALE_DIV, 0);
    write_reg(CFG_PERIOD_RELOAD, 40);
    write_reg(CFG_PULSE_MIN, 0);
    write_reg(CFG_PULSE_MAX, 16'hFFFF);
    write_reg(CFG_PULSE_CENTER, 20);
    run_phase(100);

    // Zero reload wraps on every step; the minimum lies above the maximum.
    write_reg(CFG_PRESCALE_DIV, 3);
    write_reg(CFG_PERIOD_RELOAD, 0);
    write_reg(CFG_PULSE_MIN, 30);
    write_reg(CFG_PULSE_MAX, 10);
    write_reg(CFG_PULSE_CENTER, 16'hFFFF);
    run_phase(70);

    write_reg(CFG_PRESCALE_DIV, 0);
    write_reg(CFG_PERIOD_RELOAD, 16'hFFFF);
    write_reg(CFG_PULSE_MIN, 16'hFFFF);
    write_reg(CFG_PULSE_MAX, 16'hFFFF);
    write_reg(CFG_PULSE_CENTER, 0);
    run_phase(50);

    write_reg(CFG_PRESCALE_DIV, 16'hFFFF);
    write_reg(CFG_PERIOD_RELOAD, 1);
    write_reg(CFG_PULSE_MIN, 0);
    write_reg(CFG_PULSE_MAX, 0);
    run_phase(40);

    write_reg(CFG_PRESCALE_DIV, 1);
    write_reg(CFG_PERIOD_RELOAD, 300);
    write_reg(CFG_PULSE_MIN, 50);
    write_reg(CFG_PULSE_MAX, 250);
    write_reg(CFG_PULSE_CENTER, 150);
    run_phase(120);

    write_reg(CFG_PRESCALE_DIV, 0);
    write_reg(CFG_PERIOD_RELOAD, 12);
    write_reg(CFG_PULSE_MIN, 2);
    write_reg(CFG_PULSE_MAX, 11);
    write_reg(CFG_PULSE_CENTER, 6);
    run_phase(80);

    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && pwm_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
